[rtl/mbd_pkg.sv]
// Shared types and constants for the 2x2 mip level downsampler.
package mbd_pkg;

    localparam int PIXEL_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int PAIR_W     = 9;
    localparam int LINE_W     = NUM_CHAN * PAIR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int OUT_DEPTH  = 3;
    localparam int OUT_CNT_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

    typedef struct packed {
        logic               last;
        logic [PIXEL_W-1:0] pixel;
    } out_item_t;

endpackage

[rtl/mbd_line_mem.sv]
// Line store of horizontal pair sums, one write and one registered read port.
module mbd_line_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 36
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/mbd_out_fifo.sv]
// Three-entry output queue that decouples the datapath from master-side stalls.
module mbd_out_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  mbd_pkg::out_item_t            push_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mbd_pkg::out_item_t            m_data,
    output logic [mbd_pkg::OUT_CNT_W-1:0] count
);
    import mbd_pkg::*;

    out_item_t              entry_reg [OUT_DEPTH];
    logic [OUT_CNT_W-1:0]   wr_ptr_reg;
    logic [OUT_CNT_W-1:0]   wr_ptr_next;
    logic [OUT_CNT_W-1:0]   rd_ptr_reg;
    logic [OUT_CNT_W-1:0]   rd_ptr_next;
    logic [OUT_CNT_W-1:0]   count_reg;
    logic [OUT_CNT_W-1:0]   count_next;
    logic                   pop;

    assign m_valid = (count_reg != '0);
    assign pop     = m_valid & m_ready;
    assign m_data  = entry_reg[rd_ptr_reg];
    assign count   = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == OUT_CNT_W'(OUT_DEPTH - 1)) ? '0
                        : wr_ptr_reg + OUT_CNT_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == OUT_CNT_W'(OUT_DEPTH - 1)) ? '0
                        : rd_ptr_reg + OUT_CNT_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + OUT_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && (count_reg == OUT_CNT_W'(OUT_DEPTH)) |-> pop)
        else $error("output queue overflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("output queue count out of range");

    a_push_to_head: assert property (@(posedge aclk) disable iff (!aresetn)
        push && (count_reg == '0) |=> m_valid && (m_data == $past(push_data)))
        else $error("pushed item not at head of empty queue");

endmodule

[rtl/mipmap_box_downsample_2x2_unit.sv]
// Top level: 2x2 box-filter downsampler producing one RGBA8 mip level.
// Accepts one source pixel per clock in raster order unless the output side stalls. A pair sum is
// formed when a pixel is taken; on even rows it is written to the line store,
// on odd rows the stored pair sum is read through the registered read port and the
// average is queued for output; with height one the pair sum alone is averaged.
// The average is formed from the read stage registers. A three-entry output
// queue absorbs master-side stalls; input ready drops when that queue and the
// read stage together hold three results. The line store holds MAX_WIDTH/2
// entries of 36 bits and is not initialized: no clearing pass after reset.
// Writing either configuration register restarts the frame at the next pixel.
module mipmap_box_downsample_2x2_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,   // source_pixel[31:0]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // averaged_pixel[31:0]
    output logic                           m_axis_tlast,   // frame_last
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mbd_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
    localparam int LINE_D = MAX_WIDTH / 2;
    localparam int ADDR_W = (LINE_D > 1) ? $clog2(LINE_D) : 1;
    localparam int WC_W   = (CFG_DATA_W > WD_W) ? CFG_DATA_W : WD_W;
    localparam int HC_W   = (CFG_DATA_W > HD_W) ? CFG_DATA_W : HD_W;

    // configuration
    logic [WD_W-1:0]   eff_w_reg;
    logic [HD_W-1:0]   eff_h_reg;
    logic [WD_W-1:0]   w_cfg_eff;
    logic [HD_W-1:0]   h_cfg_eff;
    logic [WC_W-1:0]   w_cfg_ext;
    logic [HC_W-1:0]   h_cfg_ext;
    logic              cfg_fire;
    logic              cfg_hit;

    // scan position and held pixel
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [31:0]       held_reg;

    // first stage
    logic              s_fire;
    logic              w_one;
    logic              h_one;
    logic              x_last;
    logic              y_last;
    logic              have_pair;
    logic              emit;
    logic              do_write;
    logic              do_read;
    logic              col_last;
    logic              row_last;
    logic [ADDR_W-1:0] idx;
    logic [LINE_W-1:0] pair;

    // read stage
    logic              s1_valid_reg;
    logic              s1_use_mem_reg;
    logic              s1_last_reg;
    logic [LINE_W-1:0] s1_pair_reg;
    logic [LINE_W-1:0] line_rd_data;
    logic [31:0]       avg;
    out_item_t         push_item;
    out_item_t         head_item;
    logic [OUT_CNT_W-1:0] fifo_count;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign cfg_hit   = cfg_fire &&
                       ((cfg_index == REG_SOURCE_WIDTH) || (cfg_index == REG_SOURCE_HEIGHT));

    assign w_cfg_ext = WC_W'(cfg_data);
    assign h_cfg_ext = HC_W'(cfg_data);

    always_comb begin
        if (w_cfg_ext == '0) begin
            w_cfg_eff = WD_W'(1);
        end else if (w_cfg_ext > WC_W'(MAX_WIDTH)) begin
            w_cfg_eff = WD_W'(MAX_WIDTH);
        end else begin
            w_cfg_eff = WD_W'(w_cfg_ext);
        end
        if (h_cfg_ext == '0) begin
            h_cfg_eff = HD_W'(1);
        end else if (h_cfg_ext > HC_W'(MAX_HEIGHT)) begin
            h_cfg_eff = HD_W'(MAX_HEIGHT);
        end else begin
            h_cfg_eff = HD_W'(h_cfg_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg <= WD_W'(2);
            eff_h_reg <= HD_W'(2);
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  eff_w_reg <= w_cfg_eff;
                REG_SOURCE_HEIGHT: eff_h_reg <= h_cfg_eff;
                default: ;
            endcase
        end
    end

    assign s_fire    = s_axis_tvalid & s_axis_tready;
    assign w_one     = (eff_w_reg == WD_W'(1));
    assign h_one     = (eff_h_reg == HD_W'(1));
    assign x_last    = (WD_W'(col_reg) + WD_W'(1)) >= eff_w_reg;
    assign y_last    = (HD_W'(row_reg) + HD_W'(1)) >= eff_h_reg;
    assign have_pair = w_one | col_reg[0];
    assign emit      = have_pair & (h_one | row_reg[0]);
    assign do_write  = s_fire & have_pair & ~h_one & ~row_reg[0] & ~y_last;
    assign do_read   = s_fire & have_pair & ~h_one & row_reg[0];
    assign idx       = ADDR_W'(col_reg >> 1);
    assign col_last  = w_one | (WD_W'(idx) == ((eff_w_reg >> 1) - WD_W'(1)));
    assign row_last  = h_one | (HD_W'(row_reg >> 1) == ((eff_h_reg >> 1) - HD_W'(1)));

    // width one pairs the pixel with itself
    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            pair[c*PAIR_W +: PAIR_W] =
                {1'b0, (w_one ? s_axis_tdata[c*CHAN_W +: CHAN_W]
                              : held_reg[c*CHAN_W +: CHAN_W])}
              + {1'b0, s_axis_tdata[c*CHAN_W +: CHAN_W]};
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (s_fire) begin
            if (x_last) begin
                col_next = '0;
                row_next = y_last ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (s_fire && !w_one && !col_reg[0] && !x_last) begin
                held_reg <= s_axis_tdata;
            end
        end
    end

    mbd_line_mem #(
        .DEPTH  (LINE_D),
        .ADDR_W (ADDR_W),
        .DATA_W (LINE_W)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (do_write),
        .wr_addr (idx),
        .wr_data (pair),
        .rd_en   (do_read),
        .rd_addr (idx),
        .rd_data (line_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_fire & emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_use_mem_reg <= ~h_one;
            s1_last_reg    <= col_last & row_last;
            s1_pair_reg    <= pair;
        end
    end

    // height one doubles the pair sum, so the average is the pair over two
    always_comb begin
        logic [PAIR_W:0] sum;
        for (int c = 0; c < NUM_CHAN; c++) begin
            sum = s1_use_mem_reg
                ? {1'b0, line_rd_data[c*PAIR_W +: PAIR_W]} + {1'b0, s1_pair_reg[c*PAIR_W +: PAIR_W]}
                : {s1_pair_reg[c*PAIR_W +: PAIR_W], 1'b0};
            avg[c*CHAN_W +: CHAN_W] = sum[PAIR_W:2];
        end
    end

    assign push_item.pixel = avg;
    assign push_item.last  = s1_last_reg;

    mbd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_valid_reg),
        .push_data (push_item),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (head_item),
        .count     (fifo_count)
    );

    assign m_axis_tdata  = head_item.pixel;
    assign m_axis_tlast  = head_item.last;
    assign s_axis_tready = ((OUT_CNT_W+1)'(fifo_count) + (OUT_CNT_W+1)'(s1_valid_reg))
                           < (OUT_CNT_W+1)'(OUT_DEPTH);

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        WD_W'(col_reg) < eff_w_reg)
        else $error("column position beyond width");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        HD_W'(row_reg) < eff_h_reg)
        else $error("row position beyond height");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> (col_reg == '0) && (row_reg == '0))
        else $error("frame did not restart after register write");

endmodule

[tb/sv/mipmap_box_downsample_2x2_unit_tb.sv]
// Testbench for the 2x2 box-filter mip downsampler: random frames checked by a predictor.
module mipmap_box_downsample_2x2_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbd_pkg::*;

    localparam int MAX_DIM        = 4096;
    localparam int LINE_DEPTH     = MAX_DIM / 2;
    localparam int RANDOM_ITEMS   = 720;
    localparam int STRESS_ITEMS   = 160;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    class downsample_scoreboard;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        int unsigned           col_pos;
        int unsigned           row_pos;
        logic [PIXEL_W-1:0]    held_pixel;
        logic [LINE_W-1:0]     pair_sum_store [LINE_DEPTH];
        out_item_t             pending_averages [$];
        int                    mismatches;

        function new();
            width_reg  = 13'd2;
            height_reg = 13'd2;
            col_pos    = 0;
            row_pos    = 0;
            held_pixel = '0;
            mismatches = 0;
        endfunction

        function int unsigned eff_dim(logic [CFG_DATA_W-1:0] v);
            if (v == 0) return 1;
            if (int'(v) > MAX_DIM) return MAX_DIM;
            return 32'(v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SOURCE_WIDTH) begin
                width_reg = data;
            end else if (idx == REG_SOURCE_HEIGHT) begin
                height_reg = data;
            end else begin
                return;
            end
            col_pos = 0;
            row_pos = 0;
        endfunction

        function void take_pixel(logic [PIXEL_W-1:0] px);
            int unsigned w, h, x, y, idx;
            int unsigned pair [NUM_CHAN];
            int unsigned total [NUM_CHAN];
            bit          have_pair;
            bit          emit;
            out_item_t   avg;
            w         = eff_dim(width_reg);
            h         = eff_dim(height_reg);
            x         = col_pos;
            y         = row_pos;
            idx       = 0;
            have_pair = 1'b0;
            emit      = 1'b0;
            avg       = '0;
            if (w == 1) begin
                foreach (pair[c]) pair[c] = 2 * px[CHAN_W*c +: CHAN_W];
                have_pair = 1'b1;
            end else if (x % 2 == 1) begin
                foreach (pair[c])
                    pair[c] = held_pixel[CHAN_W*c +: CHAN_W] + px[CHAN_W*c +: CHAN_W];
                idx       = x / 2;
                have_pair = 1'b1;
            end else if (x + 1 < w) begin
                held_pixel = px;
            end
            if (have_pair) begin
                if (h == 1) begin
                    foreach (total[c]) total[c] = 2 * pair[c];
                    emit = 1'b1;
                end else if (y % 2 == 1) begin
                    foreach (total[c])
                        total[c] = pair_sum_store[idx][PAIR_W*c +: PAIR_W] + pair[c];
                    emit = 1'b1;
                end else if (y + 1 < h) begin
                    foreach (pair[c])
                        pair_sum_store[idx][PAIR_W*c +: PAIR_W] = PAIR_W'(pair[c]);
                end
                if (emit) begin
                    foreach (total[c]) avg.pixel[CHAN_W*c +: CHAN_W] = CHAN_W'(total[c] / 4);
                    avg.last = (w == 1 || idx == w / 2 - 1) && (h == 1 || y / 2 == h / 2 - 1);
                    pending_averages.push_back(avg);
                end
            end
            if (x + 1 >= w) begin
                col_pos = 0;
                row_pos = (y + 1 >= h) ? 0 : y + 1;
            end else begin
                col_pos = x + 1;
            end
        endfunction

        function void check_result(logic [PIXEL_W-1:0] px, logic last);
            out_item_t want;
            if (pending_averages.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output transaction: pixel %h last %b", px, last);
                return;
            end
            want = pending_averages.pop_front();
            if (px !== want.pixel || last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: pixel exp %h got %h, last exp %b got %b",
                             want.pixel, px, want.last, last);
            end
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;    // source_pixel[31:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;          // averaged_pixel[31:0]
    logic                  m_axis_tlast;          // frame_last
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    downsample_scoreboard sb = new();
    int                   quiet_cycles = 0;
    int                   burst_left   = 0;
    bit                   hold_req     = 1'b0;

    logic [31:0] corner_px [8] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                   32'h00000000, 32'h80FF7F01, 32'h7F0080FE, 32'h03020100};

    mipmap_box_downsample_2x2_unit #(
        .MAX_WIDTH (MAX_DIM),
        .MAX_HEIGHT(MAX_DIM)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready) sb.take_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // output side: randomly chosen stall patterns, plus long hold-offs on request
    initial begin
        int cyc;
        int mode;
        cyc  = 0;
        mode = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc % 100 == 0) mode = $urandom_range(0, 3);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge aclk);
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (cyc % 4 != 0);
                    default: m_axis_tready <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

    function automatic logic [PIXEL_W-1:0] rand_pixel();
        logic [PIXEL_W-1:0] px;
        px = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                case ($urandom_range(0, 3))
                    0: px[CHAN_W*c +: CHAN_W] = 8'h00;
                    1: px[CHAN_W*c +: CHAN_W] = 8'hFF;
                    2: px[CHAN_W*c +: CHAN_W] = 8'h01;
                    default: px[CHAN_W*c +: CHAN_W] = 8'hFE;
                endcase
            end
        end
        return px;
    endfunction

    // entered and left at a falling edge
    task automatic send_pixel(input logic [PIXEL_W-1:0] px);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0) gap = 20;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        while (sb.pending_averages.size() != 0) @(negedge aclk);
    endtask

    task automatic pause_for_drain();
        s_axis_tvalid <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        pause_for_drain();
        cfg_write(REG_SOURCE_WIDTH, w);
        cfg_write(REG_SOURCE_HEIGHT, h);
    endtask

    initial begin
        int                    rand_items;
        int                    frame_px;
        int                    npix;
        int                    mode;
        logic [CFG_DATA_W-1:0] wr;
        logic [CFG_DATA_W-1:0] hr;
        rand_items = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset geometry 2x2: saturated frame, then a second frame right behind it
        for (int i = 0; i < 6; i++) send_pixel(corner_px[i]);
        // unused indexes mid-frame must not restart the frame
        pause_for_drain();
        cfg_write(REG_UNUSED_2, 13'h1FFF);
        cfg_write(REG_UNUSED_3, 13'h0AAA);
        for (int i = 6; i < 8; i++) send_pixel(corner_px[i]);

        configure(13'd1, 13'd1);
        send_pixel(32'hFFFFFFFF);
        send_pixel(32'h01FE7F80);
        configure(13'd0, 13'd0);
        send_pixel(32'h00000000);
        send_pixel(32'h80808080);
        configure(13'd3, 13'd3);
        for (int i = 0; i < 9; i++) send_pixel(rand_pixel());
        configure(13'd1, 13'd2);
        send_pixel(32'hFFFFFFFF);
        send_pixel(32'h00000001);

        // saturated width on a single row so every pair yields a result;
        // a long output hold-off backs the block up into its input
        configure(13'h1FFF, 13'd1);
        for (int i = 0; i < STRESS_ITEMS; i++) begin
            if (i == 20) hold_req = 1'b1;
            send_pixel(rand_pixel());
        end
        configure(13'd3, 13'h1FFF);
        for (int i = 0; i < 60; i++) send_pixel(rand_pixel());

        while (rand_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: wr = 13'd0;
                1: wr = 13'd1;
                2: wr = CFG_DATA_W'($urandom_range(13, 64));
                default: wr = CFG_DATA_W'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 9))
                0: hr = 13'd0;
                1: hr = 13'd1;
                2: hr = CFG_DATA_W'($urandom_range(9, 13'h1FFF));
                default: hr = CFG_DATA_W'($urandom_range(2, 8));
            endcase
            configure(wr, hr);
            if ($urandom_range(0, 5) == 0)
                cfg_write($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                          CFG_DATA_W'($urandom));
            frame_px = sb.eff_dim(wr) * sb.eff_dim(hr);
            mode     = $urandom_range(0, 3);
            if (mode == 0 && frame_px <= 150) begin
                npix = 2 * frame_px;
            end else if (mode <= 1 && frame_px <= 400) begin
                npix = frame_px;
            end else begin
                npix = $urandom_range(1, (frame_px < 300) ? frame_px : 300);
            end
            for (int i = 0; i < npix; i++) begin
                if ($urandom_range(0, 299) == 0) pause_for_drain();
                if ($urandom_range(0, 1999) == 0) hold_req = 1'b1;
                send_pixel(rand_pixel());
            end
            rand_items += npix;
        end

        s_axis_tvalid <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_averages.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mbd_pkg.sv
rtl/mbd_line_mem.sv
rtl/mbd_out_fifo.sv
rtl/mipmap_box_downsample_2x2_unit.sv
tb/sv/mipmap_box_downsample_2x2_unit_tb.sv
